### rtl/led_chain_pulse_serializer_defines.svh
// -----------------------------------------------------------------------------
// led_chain_pulse_serializer_defines.svh
// Assertion macros used by the serializer core (lcps_core).
// -----------------------------------------------------------------------------
`ifndef LED_CHAIN_PULSE_SERIALIZER_DEFINES_SVH
`define LED_CHAIN_PULSE_SERIALIZER_DEFINES_SVH

// property checked at every clock edge outside reset
`define LCPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define LCPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lcps_pkg.sv
// -----------------------------------------------------------------------------
// lcps_pkg
// Types and constants of the LED chain pulse serializer.
// -----------------------------------------------------------------------------
package lcps_pkg;

	localparam int TICK_W    = 16;
	localparam int CHAIN_W   = 10;
	localparam int COLOR_W   = 24;
	localparam int CIDX_W    = 5;
	localparam int REG_IDX_W = 3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_ZERO_HIGH = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_LOW  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ONE_HIGH  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ONE_LOW   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LATCH     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CHAIN     = 3'd5;

	// reset values
	localparam logic [TICK_W-1:0]  RST_ZERO_HIGH = 16'd3;
	localparam logic [TICK_W-1:0]  RST_ZERO_LOW  = 16'd15;
	localparam logic [TICK_W-1:0]  RST_ONE_HIGH  = 16'd16;
	localparam logic [TICK_W-1:0]  RST_ONE_LOW   = 16'd2;
	localparam logic [TICK_W-1:0]  RST_LATCH     = 16'd2000;
	localparam logic [CHAIN_W-1:0] RST_CHAIN     = 10'd20;

	typedef struct packed {
		logic [TICK_W-1:0]  zero_high_ticks;
		logic [TICK_W-1:0]  zero_low_ticks;
		logic [TICK_W-1:0]  one_high_ticks;
		logic [TICK_W-1:0]  one_low_ticks;
		logic [TICK_W-1:0]  latch_ticks;
		logic [CHAIN_W-1:0] chain_length;
	} cfg_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
	} res_t;

endpackage

### rtl/lcps_cfg_regs.sv
// -----------------------------------------------------------------------------
// lcps_cfg_regs
// Timing and chain length registers with their write port.
// -----------------------------------------------------------------------------
module lcps_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [lcps_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [lcps_pkg::TICK_W-1:0]        wr_data,
	output lcps_pkg::cfg_t                     cfg
);

	lcps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_high_ticks <= lcps_pkg::RST_ZERO_HIGH;
			cfg_q.zero_low_ticks  <= lcps_pkg::RST_ZERO_LOW;
			cfg_q.one_high_ticks  <= lcps_pkg::RST_ONE_HIGH;
			cfg_q.one_low_ticks   <= lcps_pkg::RST_ONE_LOW;
			cfg_q.latch_ticks     <= lcps_pkg::RST_LATCH;
			cfg_q.chain_length    <= lcps_pkg::RST_CHAIN;
		end else if (wr_en) begin
			// unknown indexes are dropped
			unique case (wr_index)
				lcps_pkg::REG_ZERO_HIGH: cfg_q.zero_high_ticks <= wr_data;
				lcps_pkg::REG_ZERO_LOW:  cfg_q.zero_low_ticks  <= wr_data;
				lcps_pkg::REG_ONE_HIGH:  cfg_q.one_high_ticks  <= wr_data;
				lcps_pkg::REG_ONE_LOW:   cfg_q.one_low_ticks   <= wr_data;
				lcps_pkg::REG_LATCH:     cfg_q.latch_ticks     <= wr_data;
				lcps_pkg::REG_CHAIN:
					cfg_q.chain_length <= wr_data[lcps_pkg::CHAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/lcps_core.sv
// -----------------------------------------------------------------------------
// lcps_core
// Frame sequencer: phase, bit, LED and tick counters, one step per transfer.
// -----------------------------------------------------------------------------
`include "led_chain_pulse_serializer_defines.svh"

module lcps_core #(
	parameter int BITS_PER_LED = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic                              command,
	input  logic [lcps_pkg::COLOR_W-1:0]      color,
	input  lcps_pkg::cfg_t                    cfg,
	output lcps_pkg::res_t                    res
);

	localparam int BIT_W = $clog2(BITS_PER_LED);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_HIGH  = 2'd1;
	localparam logic [1:0] PH_LOW   = 2'd2;
	localparam logic [1:0] PH_LATCH = 2'd3;

	logic [1:0]                       phase_q, phase_d;
	logic [lcps_pkg::COLOR_W-1:0]     color_q, color_d;
	logic [BIT_W-1:0]                 bit_pos_q, bit_pos_d;
	logic [lcps_pkg::CHAIN_W-1:0]     leds_left_q, leds_left_d;
	logic [lcps_pkg::TICK_W-1:0]      tick_q, tick_d;

	logic                             cur_bit;
	logic [lcps_pkg::CIDX_W-1:0]      color_idx;
	logic [BIT_W:0]                   bit_inc;
	logic [lcps_pkg::TICK_W-1:0]      tick_inc;
	logic [lcps_pkg::CHAIN_W-1:0]     leds_dec;
	logic [lcps_pkg::TICK_W-1:0]      high_lim, low_lim;

	// msb first; positions past the color word go out as zeros
	assign color_idx = lcps_pkg::CIDX_W'(lcps_pkg::COLOR_W - 1) -
		bit_pos_q[lcps_pkg::CIDX_W-1:0];
	assign cur_bit   = ({1'b0, bit_pos_q} < (BIT_W+1)'(lcps_pkg::COLOR_W)) ?
		color_q[color_idx] : 1'b0;
	assign bit_inc   = {1'b0, bit_pos_q} + (BIT_W+1)'(1);
	assign tick_inc  = tick_q + lcps_pkg::TICK_W'(1);
	assign leds_dec  = leds_left_q - lcps_pkg::CHAIN_W'(1);
	assign high_lim  = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
	assign low_lim   = cur_bit ? cfg.one_low_ticks  : cfg.zero_low_ticks;

	always_comb begin
		phase_d        = phase_q;
		color_d        = color_q;
		bit_pos_d      = bit_pos_q;
		leds_left_d    = leds_left_q;
		tick_d         = tick_q;
		res.line_level = 1'b0;
		res.busy_res   = 1'b0;
		res.frame_done = 1'b0;
		if (command) begin
			res.busy_res = 1'b1;
			if (phase_q == PH_IDLE) begin
				color_d     = color;
				bit_pos_d   = '0;
				leds_left_d = cfg.chain_length;
				tick_d      = '0;
				phase_d     = (cfg.chain_length == '0) ? PH_LATCH : PH_HIGH;
			end else if (phase_q == PH_HIGH) begin
				res.line_level = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_HIGH: begin
					res.line_level = 1'b1;
					res.busy_res   = 1'b1;
					tick_d         = tick_inc;
					if (tick_inc >= high_lim) begin
						tick_d  = '0;
						phase_d = PH_LOW;
					end
				end
				PH_LOW: begin
					res.busy_res = 1'b1;
					tick_d       = tick_inc;
					if (tick_inc >= low_lim) begin
						tick_d    = '0;
						phase_d   = PH_HIGH;
						bit_pos_d = bit_inc[BIT_W-1:0];
						if (bit_inc >= (BIT_W+1)'(BITS_PER_LED)) begin
							bit_pos_d   = '0;
							leds_left_d = leds_dec;
							if (leds_dec == '0)
								phase_d = PH_LATCH;
						end
					end
				end
				PH_LATCH: begin
					res.busy_res = 1'b1;
					tick_d       = tick_inc;
					if (tick_inc >= cfg.latch_ticks) begin
						tick_d         = '0;
						phase_d        = PH_IDLE;
						res.frame_done = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			color_q     <= '0;
			bit_pos_q   <= '0;
			leds_left_q <= '0;
			tick_q      <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			color_q     <= color_d;
			bit_pos_q   <= bit_pos_d;
			leds_left_q <= leds_left_d;
			tick_q      <= tick_d;
		end
	end

	`LCPS_ASSERT(a_idle_tick_clear, (phase_q != PH_IDLE) || (tick_q == '0), "idle with tick count")
	`LCPS_ASSERT(a_bit_range, {1'b0, bit_pos_q} < (BIT_W+1)'(BITS_PER_LED), "bit position out of range")
	`LCPS_ASSERT(a_leds_live, ((phase_q != PH_HIGH) && (phase_q != PH_LOW)) || (leds_left_q != '0), "sending with no LEDs left")
	`LCPS_ASSERT_NEXT(a_done_idle, step && res.frame_done, phase_q == PH_IDLE, "frame end not idle")

endmodule

### rtl/led_chain_pulse_serializer.sv
// Output timing: each result is registered and appears on m_* in the cycle after its input transfer.
// Throughput: one item per cycle while m_tready allows; the single output register lets a new item
// in whenever it is empty or being drained in the same cycle.
// Reset (arst_n low, asynchronous): registers return to their defaults, the
// sequencer goes idle and the output register empties.
// -----------------------------------------------------------------------------
// led_chain_pulse_serializer
// Pulse-width serializer for a chain of LEDs sharing one color.
// -----------------------------------------------------------------------------
module led_chain_pulse_serializer #(
	parameter int BITS_PER_LED = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lcps_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [lcps_pkg::TICK_W-1:0]     cfg_data,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [23:0]                     s_tdata,  // first_byte, second_byte, third_byte
	input  logic                            s_tuser,  // command
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,  // line_level, busy_res, zero pad
	output logic                            m_tlast   // frame_done
);

	lcps_pkg::cfg_t  cfg;
	lcps_pkg::res_t  res;
	logic            in_xfer;
	logic            out_valid_q;
	lcps_pkg::res_t  out_res_q;

	assign cfg_ready = 1'b1;

	lcps_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign s_tready = !out_valid_q || m_tready;
	assign in_xfer  = s_tvalid && s_tready;

	lcps_core #(
		.BITS_PER_LED (BITS_PER_LED)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (in_xfer),
		.command (s_tuser),
		.color   ({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_res_q.busy_res, out_res_q.line_level};
	assign m_tlast  = out_res_q.frame_done;

endmodule
